### hdl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package mcr_pkg;

  localparam int unsigned COORD_W = 8;   // pixel coordinate and centre width
  localparam int unsigned MODE_W  = 8;   // drawing mode width
  localparam int unsigned OFS_W   = 10;  // signed iteration offsets (x, y)
  localparam int unsigned DEC_W   = 11;  // signed decision value

  localparam int unsigned IN_DATA_W  = 32;  // center_x, center_y, radius, draw_mode
  localparam int unsigned OUT_DATA_W = 24;  // pixel_x, pixel_y, pixel_mode

  // Step queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Eight symmetric pixels per step
  localparam int unsigned PIX_PER_STEP = 8;
  localparam int unsigned PIX_IDX_W    = $clog2(PIX_PER_STEP);

  // Request kinds (in_tuser)
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Octant order within one step
  typedef enum logic [PIX_IDX_W-1:0] {
    OCT_PX_PY = 3'd0,
    OCT_PY_PX = 3'd1,
    OCT_NX_PY = 3'd2,
    OCT_NY_PX = 3'd3,
    OCT_NX_NY = 3'd4,
    OCT_NY_NX = 3'd5,
    OCT_PX_NY = 3'd6,
    OCT_PY_NX = 3'd7
  } oct_t;

  // One step's worth of work handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] px;    // current x offset, low byte
    logic [COORD_W-1:0] py;    // current y offset, low byte
    logic [MODE_W-1:0]  mode;
    logic               done;  // this step finishes the circle
  } job_t;

endpackage

`default_nettype wire

### hdl/mcr_front.sv
// Front end: accepts requests, holds the circle iteration state and
// queues one job per step. Depends on mcr_pkg.
`default_nettype none

module mcr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [mcr_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                          in_tuser,
  input  wire logic                          q_full,
  output logic                               q_push,
  output mcr_pkg::job_t                      q_job
);

  logic                                active_r, active_nxt;
  logic [mcr_pkg::COORD_W-1:0]         cx_r, cx_nxt;
  logic [mcr_pkg::COORD_W-1:0]         cy_r, cy_nxt;
  logic [mcr_pkg::MODE_W-1:0]          mode_r, mode_nxt;
  logic signed [mcr_pkg::OFS_W-1:0]    x_r, x_nxt;
  logic signed [mcr_pkg::OFS_W-1:0]    y_r, y_nxt;
  logic signed [mcr_pkg::DEC_W-1:0]    d_r, d_nxt;

  logic                                accept;
  logic [mcr_pkg::COORD_W-1:0]         f_cx, f_cy, f_rad;
  logic [mcr_pkg::MODE_W-1:0]          f_mode;
  logic signed [mcr_pkg::OFS_W-1:0]    x_inc, y_step;
  logic signed [mcr_pkg::DEC_W-1:0]    x_ext, diff_ext, d_step;
  logic                                step_done;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign f_cx   = in_tdata[7:0];
  assign f_cy   = in_tdata[15:8];
  assign f_rad  = in_tdata[23:16];
  assign f_mode = in_tdata[31:24];

  // Midpoint update
  always_comb begin
    x_inc    = x_r + 10'sd1;
    x_ext    = {{(mcr_pkg::DEC_W - mcr_pkg::OFS_W){x_inc[mcr_pkg::OFS_W-1]}}, x_inc};
    diff_ext = '0;
    if (d_r < 0) begin
      y_step = y_r;
      d_step = d_r + (x_ext <<< 1) + 11'sd1;
    end else begin
      y_step   = y_r - 10'sd1;
      diff_ext = x_ext - {{(mcr_pkg::DEC_W - mcr_pkg::OFS_W){y_step[mcr_pkg::OFS_W-1]}},
                          y_step};
      d_step   = d_r + (diff_ext <<< 1) + 11'sd1;
    end
    step_done = x_inc > y_step;
  end

  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    mode_nxt   = mode_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    d_nxt      = d_r;
    q_push     = 1'b0;
    if (accept) begin
      if (in_tuser == mcr_pkg::REQ_START) begin
        active_nxt = 1'b1;
        cx_nxt     = f_cx;
        cy_nxt     = f_cy;
        mode_nxt   = f_mode;
        x_nxt      = '0;
        y_nxt      = signed'({2'b00, f_rad});
        d_nxt      = 11'sd1 - signed'({3'b000, f_rad});
      end else if (active_r) begin
        q_push     = 1'b1;
        x_nxt      = x_inc;
        y_nxt      = y_step;
        d_nxt      = d_step;
        active_nxt = !step_done;
      end
    end
  end

  always_comb begin
    q_job.cx   = cx_r;
    q_job.cy   = cy_r;
    q_job.px   = x_r[mcr_pkg::COORD_W-1:0];
    q_job.py   = y_r[mcr_pkg::COORD_W-1:0];
    q_job.mode = mode_r;
    q_job.done = step_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    mode_r <= mode_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    d_r    <= d_nxt;
  end

endmodule

`default_nettype wire

### hdl/mcr_queue.sv
// Short first-in first-out queue of step jobs between front and back.
// Depends on mcr_pkg for the job type and depth.
`default_nettype none

module mcr_queue (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire mcr_pkg::job_t push_job,
  output logic         full,
  input  wire logic    pop,
  output logic         valid,
  output mcr_pkg::job_t head_job
);

  mcr_pkg::job_t                  mem_r [mcr_pkg::QDEPTH];
  logic [mcr_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mcr_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mcr_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full     = (count_r == mcr_pkg::QCNT_W'(mcr_pkg::QDEPTH));
  assign valid    = (count_r != '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mcr_pkg::QPTR_W'(mcr_pkg::QDEPTH - 1)) ? '0
                                                                      : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mcr_pkg::QPTR_W'(mcr_pkg::QDEPTH - 1)) ? '0
                                                                      : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### hdl/mcr_back.sv
// Back end: expands one step job into its eight symmetric pixels,
// one beat per cycle, unless out_tready stalls it, through a registered output. Depends on mcr_pkg.
`default_nettype none

module mcr_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  input  wire mcr_pkg::job_t                  q_job,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [mcr_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);

  mcr_pkg::job_t                     job_r, job_nxt;
  logic                              busy_r, busy_nxt;
  mcr_pkg::oct_t                     idx_r, idx_nxt;
  logic                              ovalid_r, ovalid_nxt;
  logic [mcr_pkg::OUT_DATA_W-1:0]    odata_r, odata_nxt;
  logic                              olast_r, olast_nxt;
  logic                              odone_r, odone_nxt;

  logic                              out_free, emit;
  logic [mcr_pkg::COORD_W-1:0]       nx, ny, dx, dy;

  assign out_free = !ovalid_r || out_tready;
  assign emit     = busy_r && out_free;
  assign nx       = 8'd0 - job_r.px;
  assign ny       = 8'd0 - job_r.py;

  // Octant offsets in emission order
  always_comb begin
    unique case (idx_r)
      mcr_pkg::OCT_PX_PY: begin dx = job_r.px; dy = job_r.py; end
      mcr_pkg::OCT_PY_PX: begin dx = job_r.py; dy = job_r.px; end
      mcr_pkg::OCT_NX_PY: begin dx = nx;       dy = job_r.py; end
      mcr_pkg::OCT_NY_PX: begin dx = ny;       dy = job_r.px; end
      mcr_pkg::OCT_NX_NY: begin dx = nx;       dy = ny;       end
      mcr_pkg::OCT_NY_NX: begin dx = ny;       dy = nx;       end
      mcr_pkg::OCT_PX_NY: begin dx = job_r.px; dy = ny;       end
      mcr_pkg::OCT_PY_NX: begin dx = job_r.py; dy = nx;       end
      default:            begin dx = job_r.px; dy = job_r.py; end
    endcase
  end

  always_comb begin
    job_nxt    = job_r;
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = {job_r.mode, job_r.cy + dy, job_r.cx + dx};
      olast_nxt  = (idx_r == mcr_pkg::OCT_PY_NX);
      odone_nxt  = (idx_r == mcr_pkg::OCT_PY_NX) && job_r.done;
      if (idx_r == mcr_pkg::OCT_PY_NX) begin
        // chain straight into the next queued step
        q_pop    = q_valid;
        busy_nxt = q_valid;
        job_nxt  = q_job;
        idx_nxt  = mcr_pkg::OCT_PX_PY;
      end else begin
        idx_nxt = mcr_pkg::oct_t'(idx_r + 1'b1);
      end
    end else if (!busy_r && q_valid) begin
      q_pop    = 1'b1;
      busy_nxt = 1'b1;
      job_nxt  = q_job;
      idx_nxt  = mcr_pkg::OCT_PX_PY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= mcr_pkg::OCT_PX_PY;
      ovalid_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = odone_r;

endmodule

`default_nettype wire

### hdl/midpoint_circle_rasterizer_unit.sv
// Top level of the midpoint circle rasterizer: front end, step queue, back end.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
`default_nettype none

// A start beat (in_tuser = 0) loads centre, radius and drawing mode and
// produces no output. Each step beat (in_tuser = 1) on an active
// circle produces eight pixel beats, the eight symmetric points of the
// current midpoint iteration, with out_tlast on the eighth and out_tuser
// set on that eighth beat when the circle is finished (refresh the display
// then). A step with no circle in progress is consumed silently, and a start
// while drawing abandons the old circle. The front end advances the
// iteration in the cycle a step is accepted and queues the step, up to two
// deep; the back end emits one pixel per cycle from a registered output
// while out_tready does not stall it, so the output channel sets the
// sustained step rate. Coordinates wrap modulo 256.
module midpoint_circle_rasterizer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [7:0] center_x, [15:8] center_y, [23:16] radius, [31:24] draw_mode
  input  wire logic [mcr_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] req_type
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [7:0] pixel_x, [15:8] pixel_y, [23:16] pixel_mode
  output logic [mcr_pkg::OUT_DATA_W-1:0]       out_tdata,
  // last_of_step
  output logic                                 out_tlast,
  // [0] circle_done
  output logic                                 out_tuser
);

  mcr_pkg::job_t push_job;
  mcr_pkg::job_t head_job;
  logic          q_push, q_full, q_pop, q_valid;

  mcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  mcr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_job (head_job)
  );

  mcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
